// ===== hw/rtl/ffbp_pkg.sv =====
// Shared constants and types for the first-fit block pool.
`default_nettype none
package ffbp_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int SIZE_WIDTH_DEF  = 24;

  localparam int REQ_SIZE_WIDTH = 24;
  localparam int HANDLE_WIDTH   = 6;
  localparam int STATUS_WIDTH   = 3;
  localparam int COUNT_WIDTH    = 7;
  localparam int WIDE_SIZE      = 48;
  localparam int WIDE_COUNT     = 16;

  typedef enum logic [0:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_REUSED   = 3'd0,
    ST_APPENDED = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  // what one cell reports to the controller in a scan step
  typedef struct packed {
    logic fit;        // token here, free entry big enough
    logic app;        // token here, cell unused: append point
    logic rel_hit;    // release names this cell and it is in the table
    logic rel_busy;   // ... and it was marked in use
  } cell_ev_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffbp_req_if.sv =====
// Request channel and response channel interfaces.
`default_nettype none
interface ffbp_req_if
  import ffbp_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [REQ_SIZE_WIDTH-1:0] request_size;
  logic [HANDLE_WIDTH-1:0]   block_handle;

  modport source (output valid, output opcode, output request_size, output block_handle,
                  input ready);
  modport sink   (input valid, input opcode, input request_size, input block_handle,
                  output ready);
endinterface

interface ffbp_rsp_if
  import ffbp_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic [STATUS_WIDTH-1:0] status;
  logic [HANDLE_WIDTH-1:0] granted_handle;
  logic [COUNT_WIDTH-1:0]  used_blocks;
  logic [COUNT_WIDTH-1:0]  total_blocks;

  modport source (output valid, output status, output granted_handle,
                  output used_blocks, output total_blocks, input ready);
  modport sink   (input valid, input status, input granted_handle,
                  input used_blocks, input total_blocks, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ffbp_cell.sv =====
// One table entry of the pool: size, in-use mark and the scan token.
`default_nettype none
module ffbp_cell
  import ffbp_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,     // new allocate accepted
  input  wire logic                    step,      // controller advances one step
  input  wire logic                    rel_mode,  // a release is in progress
  input  wire logic [SIZE_WIDTH-1:0]   req_size,
  input  wire logic [HANDLE_WIDTH-1:0] handle,
  input  wire logic                    pass_in,
  output logic                         pass_out,
  output cell_ev_t                     ev
);

  localparam bit ADDRESSABLE = (INDEX < (1 << HANDLE_WIDTH));
  localparam bit FIRST       = (INDEX == 0);

  logic                  token;
  logic                  present;
  logic                  busy;
  logic [SIZE_WIDTH-1:0] size;
  logic                  fits;
  logic                  sel;

  assign fits     = !busy && (size >= req_size);
  assign sel      = ADDRESSABLE && rel_mode && (handle == HANDLE_WIDTH'(INDEX));
  assign pass_out = token && present && !fits;

  assign ev.fit      = token && present && fits;
  assign ev.app      = token && !present;
  assign ev.rel_hit  = sel && present;
  assign ev.rel_busy = sel && present && busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      token   <= 1'b0;
      present <= 1'b0;
      busy    <= 1'b0;
    end else begin
      if (start) begin
        token <= FIRST;
      end else if (step) begin
        token <= pass_in;
      end
      if (step) begin
        if (ev.fit) begin
          busy <= 1'b1;
        end
        if (ev.app) begin
          present <= 1'b1;
          busy    <= 1'b1;
        end
        if (ev.rel_hit) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // payload, written only on append
  always_ff @(posedge clk) begin
    if (step && ev.app) begin
      size <= req_size;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_block_pool_unit.sv =====
// Top level of the first-fit block pool: controller and the row of entry cells.
//
// First-fit block pool. The table of TABLE_DEPTH entries lives in a row of
// cells, one entry per cell, with the used entries always forming a prefix
// from entry 0. An allocate request sends a token down the row, one cell per
// clock unless the scan is held: the first free cell whose size is at least
// the request claims the block; otherwise the first unused cell takes it as a
// new entry of the requested size; a token that leaves the last cell reports
// the table full, which makes that the longest allocate. A release is decoded
// in all cells at once. The token walk is what sets the allocate time. The
// response register lets the next request be taken while a response waits,
// but the scan only steps while the response register is empty or being
// taken: a response left waiting holds a scan or a release in place. Reset is
// synchronous and clears every in-use mark and the counts at once; block sizes
// are only read for entries already in the table.
`default_nettype none
module first_fit_block_pool_unit
  import ffbp_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int SIZE_WIDTH  = SIZE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ffbp_req_if.sink  req,
  ffbp_rsp_if.source rsp
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ALLOC = 3'b010,
    S_REL   = 3'b100
  } state_t;

  state_t state, state_next;

  // held request
  logic [SIZE_WIDTH-1:0]   req_size;
  logic [HANDLE_WIDTH-1:0] handle;
  logic [IW-1:0]           idx;        // cell the token sits at

  logic [CW-1:0] busy_count, busy_count_next;
  logic [CW-1:0] entry_count, entry_count_next;

  logic accept;
  logic start;
  logic can_out;
  logic step;
  logic finish;
  status_t fin_status;
  logic [IW-1:0] fin_idx;

  logic [WIDE_SIZE-1:0] size_wide;

  // cell row
  logic [TABLE_DEPTH:0]  pass;
  cell_ev_t              ev [TABLE_DEPTH];
  logic                  any_fit, any_app, any_rel_hit, any_rel_busy;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign start     = accept && (opcode_t'(req.opcode) == OP_ALLOC);
  assign can_out   = !rsp.valid || rsp.ready;
  assign step      = (state != S_IDLE) && can_out;
  assign size_wide = WIDE_SIZE'(req.request_size);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_size <= size_wide[SIZE_WIDTH-1:0];
      handle   <= req.block_handle;
    end
  end

  assign pass[0] = 1'b0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ffbp_cell #(
      .INDEX      (g),
      .SIZE_WIDTH (SIZE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .start    (start),
      .step     (step),
      .rel_mode (state == S_REL),
      .req_size (req_size),
      .handle   (handle),
      .pass_in  (pass[g]),
      .pass_out (pass[g+1]),
      .ev       (ev[g])
    );
  end

  // at most one cell raises each event
  always_comb begin
    any_fit      = 1'b0;
    any_app      = 1'b0;
    any_rel_hit  = 1'b0;
    any_rel_busy = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      any_fit      = any_fit      | ev[i].fit;
      any_app      = any_app      | ev[i].app;
      any_rel_hit  = any_rel_hit  | ev[i].rel_hit;
      any_rel_busy = any_rel_busy | ev[i].rel_busy;
    end
  end

  // step outcome
  always_comb begin
    finish           = 1'b0;
    fin_status       = ST_FULL;
    fin_idx          = '0;
    busy_count_next  = busy_count;
    entry_count_next = entry_count;
    state_next       = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (opcode_t'(req.opcode) == OP_ALLOC) ? S_ALLOC : S_REL;
        end
      end
      S_ALLOC: begin
        if (step) begin
          priority if (any_fit) begin
            finish          = 1'b1;
            fin_status      = ST_REUSED;
            fin_idx         = idx;
            busy_count_next = busy_count + CW'(1);
          end else if (any_app) begin
            finish           = 1'b1;
            fin_status       = ST_APPENDED;
            fin_idx          = idx;
            busy_count_next  = busy_count + CW'(1);
            entry_count_next = entry_count + CW'(1);
          end else if (idx == IW'(TABLE_DEPTH - 1)) begin
            finish     = 1'b1;
            fin_status = ST_FULL;
          end else begin
            finish = 1'b0;
          end
          if (finish) begin
            state_next = S_IDLE;
          end
        end
      end
      S_REL: begin
        if (step) begin
          finish     = 1'b1;
          fin_status = any_rel_hit ? ST_RELEASED : ST_IGNORED;
          if (any_rel_busy) begin
            busy_count_next = busy_count - CW'(1);
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      busy_count  <= '0;
      entry_count <= '0;
      idx         <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      state       <= state_next;
      busy_count  <= busy_count_next;
      entry_count <= entry_count_next;
      if (start) begin
        idx <= '0;
      end else if (step && !finish) begin
        idx <= idx + IW'(1);
      end
      if (finish) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // response register
  logic [WIDE_COUNT-1:0] idx_w, used_w, total_w;
  assign idx_w   = WIDE_COUNT'(fin_idx);
  assign used_w  = WIDE_COUNT'(busy_count_next);
  assign total_w = WIDE_COUNT'(entry_count_next);

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.status         <= fin_status;
      rsp.granted_handle <= idx_w[HANDLE_WIDTH-1:0];
      rsp.used_blocks    <= used_w[COUNT_WIDTH-1:0];
      rsp.total_blocks   <= total_w[COUNT_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the first-fit block pool: scoreboard, drivers and run control.
`timescale 1ns / 100ps

module tb_top;
  import ffbp_pkg::*;

  // Table geometry matches the defaults the unit is built with below.
  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1100;
  // Items at the tail of the run driven with no idling on either side.
  localparam int CALM_ITEMS   = 120;
  // Watchdog limit, set several times above the slowest legal run.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_MAX   = 10;

  // One response as seen on the response channel.
  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [COUNT_WIDTH-1:0]  used;
    logic [COUNT_WIDTH-1:0]  total;
  } pool_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the block table and queues the expected response of
  // every accepted request, then matches responses in order.
  // --------------------------------------------------------------------------
  class pool_scoreboard;
    logic [REQ_SIZE_WIDTH-1:0] blk_size[DEPTH];
    bit                        blk_busy[DEPTH];
    int unsigned               n_entries;
    int unsigned               n_busy;
    pool_result_t              pending[$];
    int unsigned               mismatches;
    int unsigned               checked;
    int unsigned               tally[5];

    function new();
      foreach (blk_busy[k]) blk_busy[k] = 1'b0;
      n_entries  = 0;
      n_busy     = 0;
      mismatches = 0;
      checked    = 0;
      foreach (tally[k]) tally[k] = 0;
    endfunction

    // First-fit allocate or release; returns the predicted status.
    function logic [STATUS_WIDTH-1:0] note_request(opcode_t op,
                                                   logic [REQ_SIZE_WIDTH-1:0] size,
                                                   logic [HANDLE_WIDTH-1:0] handle);
      pool_result_t r;
      bit           granted;
      r        = '0;
      granted  = 1'b0;
      if (op == OP_ALLOC) begin
        for (int k = 0; k < n_entries; k++) begin
          if (!granted && !blk_busy[k] && blk_size[k] >= size) begin
            blk_busy[k] = 1'b1;
            n_busy++;
            r.status = ST_REUSED;
            r.handle = HANDLE_WIDTH'(k);
            granted  = 1'b1;
          end
        end
        if (!granted) begin
          if (n_entries < DEPTH) begin
            blk_size[n_entries] = size;
            blk_busy[n_entries] = 1'b1;
            r.handle = HANDLE_WIDTH'(n_entries);
            n_entries++;
            n_busy++;
            r.status = ST_APPENDED;
          end else begin
            r.status = ST_FULL;
          end
        end
      end else begin
        if (handle >= n_entries) begin
          r.status = ST_IGNORED;
        end else begin
          // releasing a free entry still reports released, count unchanged
          if (blk_busy[handle]) begin
            blk_busy[handle] = 1'b0;
            n_busy--;
          end
          r.status = ST_RELEASED;
        end
      end
      r.used  = COUNT_WIDTH'(n_busy);
      r.total = COUNT_WIDTH'(n_entries);
      pending = {pending, r};
      tally[r.status]++;
      return r.status;
    endfunction

    function void check_response(pool_result_t got);
      pool_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] response with no request outstanding: status %0d handle %0d",
                   $realtime, got.status, got.handle);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.handle !== want.handle ||
          got.used !== want.used || got.total !== want.total) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"[%0t] mismatch: status exp %0d got %0d, handle exp %0d got %0d, ",
                    "used exp %0d got %0d, total exp %0d got %0d"},
                   $realtime, want.status, got.status, want.handle, got.handle,
                   want.used, got.used, want.total, got.total);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ffbp_req_if req_bus ();
  ffbp_rsp_if rsp_bus ();

  first_fit_block_pool_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus.sink),
    .rsp (rsp_bus.source)
  );

  pool_scoreboard sb;
  pool_result_t   seen;
  int unsigned    cycle_count;
  // 0 = no idling, 1 = light, 2 = heavy; rerolled every few dozen requests
  int unsigned    idle_mode;
  bit             calm;

  // Clock and reset: reset is asserted once, at the start, never again.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    sb        = new();
    idle_mode = 0;
    calm      = 1'b0;
    rst      <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst      <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, sb.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial cycle_count = 0;

  // --------------------------------------------------------------------------
  // Response side: sample on the edge, check every accepted response.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      seen.status = rsp_bus.status;
      seen.handle = rsp_bus.granted_handle;
      seen.used   = rsp_bus.used_blocks;
      seen.total  = rsp_bus.total_blocks;
      sb.check_response(seen);
    end
  end

  // Ready back-pressure: random stall bursts, none once calm or while idle_mode is 0.
  // Each pass assigns ready at most once per edge.
  initial begin
    rsp_bus.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      rsp_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!calm && idle_mode != 0 &&
          $urandom_range(0, (idle_mode == 2) ? 1 : 5) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  // Present one request, hold it until accepted, then log it with the
  // scoreboard. Valid stays high straight into the next request unless an
  // idle burst is drawn, so valid never sees two assignments in one step.
  task automatic send_request(input opcode_t op,
                              input logic [REQ_SIZE_WIDTH-1:0] size,
                              input logic [HANDLE_WIDTH-1:0] handle,
                              output logic [STATUS_WIDTH-1:0] st);
    if (!calm && idle_mode != 0 &&
        $urandom_range(0, (idle_mode == 2) ? 2 : 6) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.opcode       <= op;
    req_bus.request_size <= size;
    req_bus.block_handle <= handle;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    st = sb.note_request(op, size, handle);
  endtask

  // Allocation size: a spread of widths, exact and just-too-big fits against
  // live entries, and the extremes.
  function automatic logic [REQ_SIZE_WIDTH-1:0] pick_size();
    logic [REQ_SIZE_WIDTH-1:0] s;
    int unsigned               k;
    s = REQ_SIZE_WIDTH'($urandom);
    case ($urandom_range(0, 5))
      0: s = REQ_SIZE_WIDTH'($urandom_range(0, 255));
      1: s = s & ((REQ_SIZE_WIDTH'(1) << $urandom_range(0, REQ_SIZE_WIDTH - 1)) -
                  REQ_SIZE_WIDTH'(1));
      2: s = ($urandom_range(0, 1) == 0) ? '1 : '0;
      3, 4: begin
        if (sb.n_entries != 0) begin
          k = $urandom_range(0, sb.n_entries - 1);
          s = sb.blk_size[k];
          // one above an entry's size: that entry must be skipped
          if ($urandom_range(0, 1) == 0 && s != '1) s = s + 1'b1;
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    logic [STATUS_WIDTH-1:0] st;
    int unsigned             n_sent;
    opcode_t                 op;
    logic [HANDLE_WIDTH-1:0] h;

    req_bus.valid        <= 1'b0;
    req_bus.opcode       <= OP_ALLOC;
    req_bus.request_size <= '0;
    req_bus.block_handle <= '0;
    do @(posedge clk); while (rst !== 1'b0);

    // Directed opening: size extremes, zero-size reuse, first-fit skipping a
    // busy and a too-small entry, double release, releases past the table end.
    send_request(OP_ALLOC,   24'h000000, 6'd63, st);  // append entry 0, size zero
    send_request(OP_ALLOC,   24'hFFFFFF, 6'd0,  st);  // append entry 1, max size
    send_request(OP_ALLOC,   24'h000100, 6'd42, st);  // append entry 2
    send_request(OP_RELEASE, 24'hFFFFFF, 6'd0,  st);  // release entry 0
    send_request(OP_RELEASE, 24'h000000, 6'd0,  st);  // already free: still released
    send_request(OP_RELEASE, 24'h123456, 6'd63, st);  // beyond table: ignored
    send_request(OP_RELEASE, 24'h000000, 6'd3,  st);  // one past the end: ignored
    send_request(OP_ALLOC,   24'h000000, 6'd21, st);  // zero size reuses entry 0
    send_request(OP_RELEASE, 24'h000000, 6'd1,  st);
    send_request(OP_ALLOC,   24'h800000, 6'd0,  st);  // skips busy 0, reuses 1
    send_request(OP_RELEASE, 24'h000000, 6'd2,  st);
    send_request(OP_ALLOC,   24'h000101, 6'd0,  st);  // entry 2 too small: append
    send_request(OP_ALLOC,   24'h0000FF, 6'd0,  st);  // fits free entry 2
    send_request(OP_ALLOC,   24'hAAAAAA, 6'd63, st);
    send_request(OP_ALLOC,   24'h555555, 6'd0,  st);
    send_request(OP_RELEASE, 24'hAAAAAA, 6'd42, st);  // ignored
    send_request(OP_RELEASE, 24'h555555, 6'd21, st);  // ignored
    send_request(OP_ALLOC,   24'hFFFFFF, 6'd0,  st);  // nothing free fits: append

    // Random part. The table only grows, so it fills early and most of the
    // run exercises reuse, table full and release against a full table.
    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      if (n_sent % 80 == 0) idle_mode = $urandom_range(0, 2);
      if (n_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      op = ($urandom_range(0, 99) < 42) ? OP_RELEASE : OP_ALLOC;
      h  = HANDLE_WIDTH'($urandom);
      if (op == OP_RELEASE && sb.n_entries != 0 && $urandom_range(0, 3) != 0)
        h = HANDLE_WIDTH'($urandom_range(0, sb.n_entries - 1));
      send_request(op, (op == OP_ALLOC) ? pick_size() : REQ_SIZE_WIDTH'($urandom), h, st);
      // releases the block ignores do not count towards the total
      if (st != ST_IGNORED) n_sent++;
    end
    req_bus.valid <= 1'b0;

    // Drain, then allow one full scan for anything stray.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("requests: %0d reused, %0d appended, %0d table full, %0d released, %0d ignored",
             sb.tally[ST_REUSED], sb.tally[ST_APPENDED], sb.tally[ST_FULL],
             sb.tally[ST_RELEASED], sb.tally[ST_IGNORED]);
    $display("responses checked %0d, mismatches %0d, final table %0d entries / %0d in use",
             sb.checked, sb.mismatches, sb.n_entries, sb.n_busy);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
